/* src/nexa_ook_pkg.sv */
// Shared types and constants for the Nexa OOK frame transmitter.
// No dependencies; imported by the top level, the port checker and the bench files.
package nexa_ook_pkg;

   localparam int unsigned ADDRESS_BITS_DEF       = 26;
   localparam int unsigned TICK_COUNTER_WIDTH_DEF = 16;

   localparam int unsigned CODE_W      = 26;
   localparam int unsigned UNIT_W      = 4;
   localparam int unsigned LEVEL_W     = 4;
   localparam int unsigned PULSE_W     = 10;
   localparam int unsigned STOP_GAP_W  = 16;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [PULSE_W-1:0]    PULSE_RESET    = 10'd296;
   localparam logic [STOP_GAP_W-1:0] STOP_GAP_RESET = 16'd10840;

   // Start gap is 10.5 base pulses, long symbol gap is 5 base pulses.
   localparam int unsigned START_GAP_MULT = 10;
   localparam int unsigned LONG_GAP_MULT  = 5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PULSE_TICKS    = 2'd0,
      CSR_STOP_GAP_TICKS = 2'd1
   } csr_index_type;

   typedef enum logic [0:0] {
      KIND_TICK    = 1'b0,
      KIND_COMMAND = 1'b1
   } item_kind_type;

   typedef enum logic [3:0] {
      SEC_IDLE  = 4'b0001,
      SEC_START = 4'b0010,
      SEC_DATA  = 4'b0100,
      SEC_STOP  = 4'b1000
   } section_type;

endpackage

/* src/nexa_ook_frame_transmitter_top.sv */
// Nexa 433 MHz OOK frame transmitter: frame loader, phase sequencer, result register.
// Depends on nexa_ook_pkg.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------------------
//   req_    | in        | req_valid / req_ready | kind, command fields
//   rsp_    | out       | rsp_valid / rsp_ready | pin_level, busy_res, frame_done, rejected
//   csr_    | in        | csr_valid / csr_ready | csr_index, csr_data
//
// One item per clock while the result register can take it: each item's state update
// and result are computed combinationally and land in the result register on the accepting edge.
// A new item is accepted whenever the result register is empty or being drained.
// rsp_ready low stalls req_ready only while a result is held.
// Reset is synchronous: section goes idle, result register empties, registers take
// their defaults (pulse 296 ticks, stop gap 10840 ticks). csr_ready is always high.
module nexa_ook_frame_transmitter_top #(
   parameter int unsigned ADDRESS_BITS       = nexa_ook_pkg::ADDRESS_BITS_DEF,
   parameter int unsigned TICK_COUNTER_WIDTH = nexa_ook_pkg::TICK_COUNTER_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic                                 req_turn_on,
   input  logic [nexa_ook_pkg::CODE_W-1:0]      req_transmitter_code,
   input  logic                                 req_is_group,
   input  logic [nexa_ook_pkg::UNIT_W-1:0]      req_unit_number,
   input  logic [nexa_ook_pkg::LEVEL_W-1:0]     req_dim_level,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_pin_level,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_frame_done,
   output logic                                 rsp_rejected,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [nexa_ook_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nexa_ook_pkg::CSR_DATA_W-1:0]  csr_data
);
   import nexa_ook_pkg::*;

   localparam int unsigned MAX_SYM  = 2 * ADDRESS_BITS + 20;
   localparam int unsigned ADDR_SYM = 2 * ADDRESS_BITS;
   localparam int unsigned CNT_W    = $clog2(MAX_SYM + 1);
   localparam int unsigned TW       = TICK_COUNTER_WIDTH;
   localparam logic [32:0] CNT_MAX_WIDE = (33'd1 << TW) - 33'd1;
   localparam logic [31:0] CNT_MAX      = CNT_MAX_WIDE[31:0];
   localparam logic [CNT_W-1:0] TOTAL_PLAIN = CNT_W'(ADDR_SYM + 12);
   localparam logic [CNT_W-1:0] TOTAL_DIM   = CNT_W'(ADDR_SYM + 20);

   function automatic logic [TW-1:0] sat_count(input logic [31:0] v);
      logic [31:0] s;
      s = (v > CNT_MAX) ? CNT_MAX : v;
      return s[TW-1:0];
   endfunction

   // configuration registers
   logic [PULSE_W-1:0]    pulse_ff;
   logic [STOP_GAP_W-1:0] stop_gap_ff;

   // frame state
   section_type           section_ff, section_in;
   logic                  high_ff, high_in;
   logic [TW-1:0]         ticks_ff, ticks_in;
   logic [MAX_SYM-1:0]    store_ff, store_in;
   logic [CNT_W-1:0]      left_ff, left_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  pin_ff, pin_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  rej_ff, rej_in;

   logic                  in_fire;
   logic [PULSE_W-1:0]    base_p;
   logic [31:0]           p32;
   logic [MAX_SYM-1:0]    load_vec;
   logic [ADDRESS_BITS+CODE_W-1:0] code_wide;
   logic                  dim;
   logic                  bit_v;
   logic [TW-1:0]         ticks_dec;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign in_fire   = req_valid && req_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pin_level  = pin_ff;
   assign rsp_busy_res   = busy_ff;
   assign rsp_frame_done = done_ff;
   assign rsp_rejected   = rej_ff;

   assign base_p    = (pulse_ff == '0) ? PULSE_W'(1) : pulse_ff;
   assign p32       = 32'(base_p);
   assign dim       = (req_dim_level != '0);
   assign ticks_dec = (ticks_ff != '0) ? ticks_ff - TW'(1) : ticks_ff;
   // address bits past the code field read as zero
   assign code_wide = {ADDRESS_BITS'(0), req_transmitter_code};

   // Symbol vector, first symbol in bit 0; a set bit means a long gap.
   always_comb begin
      load_vec = '0;
      for (int j = 0; j < int'(ADDRESS_BITS); j++) begin
         bit_v           = code_wide[ADDRESS_BITS-1-j];
         load_vec[2*j]   = bit_v;
         load_vec[2*j+1] = !bit_v;
      end
      load_vec[ADDR_SYM]   = req_is_group;
      load_vec[ADDR_SYM+1] = !req_is_group;
      // dim marker is two short symbols
      load_vec[ADDR_SYM+2] = dim ? 1'b0 : req_turn_on;
      load_vec[ADDR_SYM+3] = dim ? 1'b0 : !req_turn_on;
      for (int r = 0; r < 4; r++) begin
         load_vec[ADDR_SYM+4+2*r] = req_is_group || req_unit_number[3-r];
         load_vec[ADDR_SYM+5+2*r] = !(req_is_group || req_unit_number[3-r]);
         load_vec[ADDR_SYM+12+2*r] = dim && req_dim_level[3-r];
         load_vec[ADDR_SYM+13+2*r] = dim && !req_dim_level[3-r];
      end
   end

   always_comb begin
      section_in = section_ff;
      high_in    = high_ff;
      ticks_in   = ticks_ff;
      store_in   = store_ff;
      left_in    = left_ff;
      pin_in     = 1'b0;
      busy_in    = 1'b0;
      done_in    = 1'b0;
      rej_in     = 1'b0;

      if (req_kind == KIND_COMMAND) begin
         busy_in = 1'b1;
         if (section_ff != SEC_IDLE) begin
            rej_in = 1'b1;
            pin_in = high_ff;
         end else begin
            store_in   = load_vec;
            left_in    = dim ? TOTAL_DIM : TOTAL_PLAIN;
            section_in = SEC_START;
            high_in    = 1'b1;
            ticks_in   = sat_count(p32);
            pin_in     = 1'b1;
         end
      end else if (section_ff != SEC_IDLE) begin
         busy_in  = 1'b1;
         pin_in   = high_ff;
         ticks_in = ticks_dec;
         if (ticks_dec == '0) begin
            unique case (section_ff)
               SEC_START: begin
                  if (high_ff) begin
                     high_in  = 1'b0;
                     ticks_in = sat_count(p32 * START_GAP_MULT + (p32 >> 1));
                  end else begin
                     section_in = SEC_DATA;
                     high_in    = 1'b1;
                     ticks_in   = sat_count(p32);
                  end
               end
               SEC_DATA: begin
                  if (high_ff) begin
                     high_in  = 1'b0;
                     ticks_in = sat_count(store_ff[0] ? p32 * LONG_GAP_MULT : p32);
                  end else begin
                     // advance to the next symbol
                     store_in = store_ff >> 1;
                     left_in  = left_ff - CNT_W'(1);
                     if (left_ff <= CNT_W'(1)) begin
                        section_in = SEC_STOP;
                     end
                     high_in  = 1'b1;
                     ticks_in = sat_count(p32);
                  end
               end
               SEC_STOP: begin
                  if (high_ff && stop_gap_ff != '0) begin
                     high_in  = 1'b0;
                     ticks_in = sat_count(32'(stop_gap_ff));
                  end else begin
                     section_in = SEC_IDLE;
                     high_in    = 1'b0;
                     ticks_in   = '0;
                     done_in    = 1'b1;
                  end
               end
               default: begin
                  section_in = SEC_IDLE;
                  high_in    = 1'b0;
                  ticks_in   = '0;
               end
            endcase
         end
      end
   end

   assign rsp_valid_in = in_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         section_ff   <= SEC_IDLE;
         high_ff      <= 1'b0;
         ticks_ff     <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         pulse_ff     <= PULSE_RESET;
         stop_gap_ff  <= STOP_GAP_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (in_fire) begin
            section_ff <= section_in;
            high_ff    <= high_in;
            ticks_ff   <= ticks_in;
            left_ff    <= left_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PULSE_TICKS:    pulse_ff    <= csr_data[PULSE_W-1:0];
               CSR_STOP_GAP_TICKS: stop_gap_ff <= csr_data[STOP_GAP_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      if (in_fire) begin
         store_ff <= store_in;
         pin_ff   <= pin_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         rej_ff   <= rej_in;
      end
   end

endmodule

/* src/nexa_ook_checker.sv */
// Port-level checker for the Nexa OOK frame transmitter, bound to the top level.
// Depends on nexa_ook_pkg, which it imports.
module nexa_ook_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_pin_level,
   input logic rsp_busy_res,
   input logic rsp_frame_done,
   input logic rsp_rejected
);
   import nexa_ook_pkg::*;

   // hold a stalled transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pin_level)
         && $stable(rsp_busy_res) && $stable(rsp_frame_done) && $stable(rsp_rejected))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_pin_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pin_level |-> rsp_busy_res)
      else $error("pin high while idle");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_busy_res && !rsp_rejected)
      else $error("frame end on an idle or rejected transaction");

   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_busy_res)
      else $error("rejection while idle");

endmodule

bind nexa_ook_frame_transmitter_top nexa_ook_checker u_nexa_ook_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_pin_level  (rsp_pin_level),
   .rsp_busy_res   (rsp_busy_res),
   .rsp_frame_done (rsp_frame_done),
   .rsp_rejected   (rsp_rejected)
);

/* bench/nexa_ook_waveform_checker.sv */
`timescale 1ns / 100ps
// Pin waveform checker for the Nexa OOK frame transmitter: predicts each result
// from accepted requests and register writes, and compares it with the rsp_ channel.
// Depends on nexa_ook_pkg.
module nexa_ook_waveform_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic                                 req_turn_on,
   input  logic [nexa_ook_pkg::CODE_W-1:0]      req_transmitter_code,
   input  logic                                 req_is_group,
   input  logic [nexa_ook_pkg::UNIT_W-1:0]      req_unit_number,
   input  logic [nexa_ook_pkg::LEVEL_W-1:0]     req_dim_level,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic                                 rsp_pin_level,
   input  logic                                 rsp_busy_res,
   input  logic                                 rsp_frame_done,
   input  logic                                 rsp_rejected,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [nexa_ook_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nexa_ook_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                                   mismatch_count,
   output int                                   results_owed
);
   import nexa_ook_pkg::*;

   localparam int unsigned SYMBOL_SLOTS = 2 * ADDRESS_BITS_DEF + 20;
   localparam int unsigned PHASE_MAX    = (1 << TICK_COUNTER_WIDTH_DEF) - 1;
   localparam int          PRINT_CAP    = 100;

   typedef struct packed {
      logic pin_level;
      logic busy;
      logic frame_done;
      logic rejected;
   } pin_sample_type;

   logic [PULSE_W-1:0]    pulse_len;
   logic [STOP_GAP_W-1:0] stop_gap;
   logic [SYMBOL_SLOTS-1:0] gap_is_long;
   int unsigned           symbol_count;
   int unsigned           symbol_index;
   section_type           section;
   logic                  pulse_high;
   int unsigned           phase_ticks_left;
   int                    result_number;
   pin_sample_type        pin_samples_due[$];

   function automatic int unsigned clamp_phase(input int unsigned n);
      return (n > PHASE_MAX) ? PHASE_MAX : n;
   endfunction

   function automatic int unsigned unit_pulse();
      return (pulse_len == 0) ? 1 : int'(pulse_len);
   endfunction

   function automatic void go_quiet();
      section          = SEC_IDLE;
      pulse_high       = 1'b0;
      phase_ticks_left = 0;
   endfunction

   function automatic void push_gap(input logic long_gap);
      if (symbol_count < SYMBOL_SLOTS) begin
         gap_is_long[symbol_count] = long_gap;
         symbol_count++;
      end
   endfunction

   // Manchester pair: the bit, then its complement; a long gap stands for one.
   function automatic void push_bit(input logic b);
      push_gap(b);
      push_gap(!b);
   endfunction

   function automatic void load_frame(input logic turn_on, input logic [CODE_W-1:0] code,
                                      input logic group, input logic [UNIT_W-1:0] unit,
                                      input logic [LEVEL_W-1:0] level);
      int i;
      symbol_count = 0;
      for (i = CODE_W - 1; i >= 0; i--)
         push_bit(code[i]);
      push_bit(group);
      if (level != 0) begin
         // dim marker: two short symbols
         push_gap(1'b0);
         push_gap(1'b0);
      end else begin
         push_bit(turn_on);
      end
      for (i = UNIT_W - 1; i >= 0; i--)
         push_bit(group ? 1'b1 : unit[i]);
      if (level != 0)
         for (i = LEVEL_W - 1; i >= 0; i--)
            push_bit(level[i]);
      symbol_index     = 0;
      section          = SEC_START;
      pulse_high       = 1'b1;
      phase_ticks_left = clamp_phase(unit_pulse());
   endfunction

   // Enter the phase after the one that just ran out; return one at frame end.
   function automatic logic advance_phase();
      int unsigned p;
      logic        long_gap;
      logic        ended;
      p     = unit_pulse();
      ended = 1'b0;
      case (section)
         SEC_START: begin
            if (pulse_high) begin
               pulse_high       = 1'b0;
               phase_ticks_left = clamp_phase(p * START_GAP_MULT + p / 2);
            end else begin
               section          = SEC_DATA;
               symbol_index     = 0;
               pulse_high       = 1'b1;
               phase_ticks_left = clamp_phase(p);
            end
         end
         SEC_DATA: begin
            if (pulse_high) begin
               long_gap         = (symbol_index < symbol_count) ? gap_is_long[symbol_index]
                                                                : 1'b0;
               pulse_high       = 1'b0;
               phase_ticks_left = clamp_phase(long_gap ? p * LONG_GAP_MULT : p);
            end else begin
               symbol_index++;
               if (symbol_index >= symbol_count)
                  section = SEC_STOP;
               pulse_high       = 1'b1;
               phase_ticks_left = clamp_phase(p);
            end
         end
         SEC_STOP: begin
            if (pulse_high && stop_gap != 0) begin
               pulse_high       = 1'b0;
               phase_ticks_left = clamp_phase(stop_gap);
            end else begin
               go_quiet();
               ended = 1'b1;
            end
         end
         default: go_quiet();
      endcase
      return ended;
   endfunction

   function automatic pin_sample_type next_pin_sample(input item_kind_type kind,
                                                      input logic turn_on,
                                                      input logic [CODE_W-1:0] code,
                                                      input logic group,
                                                      input logic [UNIT_W-1:0] unit,
                                                      input logic [LEVEL_W-1:0] level);
      pin_sample_type s;
      s = '0;
      if (kind == KIND_COMMAND) begin
         if (section != SEC_IDLE)
            s.rejected = 1'b1;
         else
            load_frame(turn_on, code, group, unit, level);
         s.busy      = (section != SEC_IDLE);
         s.pin_level = s.busy & pulse_high;
      end else if (section != SEC_IDLE) begin
         s.busy      = 1'b1;
         s.pin_level = pulse_high;
         if (phase_ticks_left > 0)
            phase_ticks_left--;
         if (phase_ticks_left == 0)
            s.frame_done = advance_phase();
      end
      return s;
   endfunction

   // Count every mismatch; print only the first few to keep the log short.
   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_CAP)
         $display("%0t ns: result %0d: %s", $time, result_number, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string field, input logic due, input logic seen);
      if (seen !== due)
         report_mismatch($sformatf("%s expected %0b, got %0b", field, due, seen));
   endtask

   always @(posedge clock) begin
      pin_sample_type due;
      if (reset) begin
         pulse_len      = PULSE_RESET;
         stop_gap       = STOP_GAP_RESET;
         gap_is_long    = '0;
         symbol_count   = 0;
         symbol_index   = 0;
         go_quiet();
         pin_samples_due.delete();
         mismatch_count = 0;
         result_number  = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PULSE_TICKS:    pulse_len = csr_data[PULSE_W-1:0];
               CSR_STOP_GAP_TICKS: stop_gap  = csr_data[STOP_GAP_W-1:0];
               default: ;
            endcase
         end
         // Compare before predicting: a result never belongs to the request
         // accepted on the same edge.
         if (rsp_valid && rsp_ready) begin
            if (pin_samples_due.size() == 0) begin
               report_mismatch("result transaction with no request waiting");
            end else begin
               due = pin_samples_due.pop_front();
               check_field("pin_level", due.pin_level, rsp_pin_level);
               check_field("busy_res", due.busy, rsp_busy_res);
               check_field("frame_done", due.frame_done, rsp_frame_done);
               check_field("rejected", due.rejected, rsp_rejected);
            end
            result_number++;
         end
         if (req_valid && req_ready)
            pin_samples_due.push_back(next_pin_sample(item_kind_type'(req_kind), req_turn_on,
                                                      req_transmitter_code, req_is_group,
                                                      req_unit_number, req_dim_level));
      end
      results_owed <= pin_samples_due.size();
   end

endmodule

/* bench/nexa_ook_frame_transmitter_top_test.sv */
`timescale 1ns / 100ps
// Testbench top for the Nexa OOK frame transmitter: clock, reset, request and
// register stimulus, receiver stalls and the verdict. Depends on nexa_ook_pkg,
// nexa_ook_frame_transmitter_top and nexa_ook_waveform_checker.
module nexa_ook_frame_transmitter_top_test;
   import nexa_ook_pkg::*;

   localparam int          WATCHDOG_LIMIT   = 3000;
   localparam int          HOLD_OFF_CYCLES  = 300;
   localparam int          SEGMENT_ITEMS    = 100;
   localparam int          SEGMENTS         = 8;
   localparam logic [CODE_W-1:0] CODE_ONES  = '1;

   typedef struct {
      item_kind_type         kind;
      logic                  turn_on;
      logic [CODE_W-1:0]     code;
      logic                  is_group;
      logic [UNIT_W-1:0]     unit;
      logic [LEVEL_W-1:0]    level;
   } frame_request_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_kind;
   logic                   req_turn_on;
   logic [CODE_W-1:0]      req_transmitter_code;
   logic                   req_is_group;
   logic [UNIT_W-1:0]      req_unit_number;
   logic [LEVEL_W-1:0]     req_dim_level;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_pin_level;
   logic                   rsp_busy_res;
   logic                   rsp_frame_done;
   logic                   rsp_rejected;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   int                     mismatch_count;
   int                     results_owed;

   int                     send_gap_pct;
   int                     stall_pct;
   int                     hold_offs_asked;
   int                     hold_offs_done;
   int                     idle_cycles = 0;
   int unsigned            ticks_to_idle;
   logic [PULSE_W-1:0]     pulse_copy;
   logic [STOP_GAP_W-1:0]  stop_copy;
   int                     items_sent;
   int                     frames_sent;
   int                     commands_refused;

   nexa_ook_frame_transmitter_top u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_turn_on          (req_turn_on),
      .req_transmitter_code (req_transmitter_code),
      .req_is_group         (req_is_group),
      .req_unit_number      (req_unit_number),
      .req_dim_level        (req_dim_level),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_pin_level        (rsp_pin_level),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_frame_done       (rsp_frame_done),
      .rsp_rejected         (rsp_rejected),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   nexa_ook_waveform_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_turn_on          (req_turn_on),
      .req_transmitter_code (req_transmitter_code),
      .req_is_group         (req_is_group),
      .req_unit_number      (req_unit_number),
      .req_dim_level        (req_dim_level),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_pin_level        (rsp_pin_level),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_frame_done       (rsp_frame_done),
      .rsp_rejected         (rsp_rejected),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .mismatch_count       (mismatch_count),
      .results_owed         (results_owed)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Receiver: random stalls, plus one long hold-off counted here on request.
   initial begin
      rsp_ready      = 1'b0;
      hold_offs_done = 0;
      forever begin
         @(negedge clock);
         if (hold_offs_done != hold_offs_asked) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_offs_done++;
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   // Ticks from command to frame end, for pacing: every Manchester pair costs
   // eight pulses, the dim marker four.
   function automatic int unsigned frame_ticks(input frame_request_type r);
      int unsigned p;
      int unsigned pairs;
      p     = (pulse_copy == 0) ? 1 : int'(pulse_copy);
      pairs = CODE_W + 1 + UNIT_W + ((r.level != 0) ? LEVEL_W : 1);
      return p + START_GAP_MULT * p + p / 2 + pairs * 8 * p + ((r.level != 0) ? 4 * p : 0)
             + p + stop_copy;
   endfunction

   function automatic frame_request_type random_request(input item_kind_type kind);
      frame_request_type r;
      r.kind     = kind;
      r.turn_on  = 1'($urandom_range(1));
      r.code     = CODE_W'($urandom());
      r.is_group = 1'($urandom_range(1));
      r.unit     = UNIT_W'($urandom_range(15));
      r.level    = $urandom_range(1) ? '0 : LEVEL_W'($urandom_range(15));
      return r;
   endfunction

   // Offer one request transaction; return at the falling edge after acceptance.
   task automatic offer(input frame_request_type r);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid            <= 1'b1;
      req_kind             <= r.kind;
      req_turn_on          <= r.turn_on;
      req_transmitter_code <= r.code;
      req_is_group         <= r.is_group;
      req_unit_number      <= r.unit;
      req_dim_level        <= r.level;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
      if (r.kind == KIND_COMMAND) begin
         if (ticks_to_idle == 0) begin
            ticks_to_idle = frame_ticks(r);
            frames_sent++;
         end else begin
            commands_refused++;
         end
      end else if (ticks_to_idle != 0) begin
         ticks_to_idle--;
      end
   endtask

   task automatic finish_frame();
      while (ticks_to_idle != 0)
         offer(random_request(KIND_TICK));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (results_owed != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      if (index == CSR_PULSE_TICKS)
         pulse_copy = data[PULSE_W-1:0];
      else if (index == CSR_STOP_GAP_TICKS)
         stop_copy = data[STOP_GAP_W-1:0];
   endtask

   // Write both registers while the block is idle; optionally poke an unused index.
   task automatic configure(input logic [CSR_DATA_W-1:0] pulse_data,
                            input logic [CSR_DATA_W-1:0] stop_data, input bit poke_unused);
      drain_results();
      write_register(CSR_PULSE_TICKS, pulse_data);
      if (poke_unused)
         write_register({1'b1, 1'($urandom_range(1))}, CSR_DATA_W'($urandom()));
      write_register(CSR_STOP_GAP_TICKS, stop_data);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int seg;
      int n;
      bit send_command;
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_kind             = KIND_TICK;
      req_turn_on          = 1'b0;
      req_transmitter_code = '0;
      req_is_group         = 1'b0;
      req_unit_number      = '0;
      req_dim_level        = '0;
      csr_valid            = 1'b0;
      csr_index            = CSR_PULSE_TICKS;
      csr_data             = '0;
      send_gap_pct         = 0;
      stall_pct            = 0;
      hold_offs_asked      = 0;
      ticks_to_idle        = 0;
      pulse_copy           = PULSE_RESET;
      stop_copy            = STOP_GAP_RESET;
      items_sent           = 0;
      frames_sent          = 0;
      commands_refused     = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Ticks while idle, one with every field at its top value.
      offer(random_request(KIND_TICK));
      offer('{KIND_TICK, 1'b1, CODE_ONES, 1'b1, '1, '1});

      // Pulse field zero behaves as one tick; no stop gap.
      configure(16'hFC00, 16'h0000, 1'b0);
      offer('{KIND_COMMAND, 1'b1, CODE_ONES, 1'b0, '1, '0});
      repeat (20) offer(random_request(KIND_TICK));
      offer('{KIND_COMMAND, 1'b1, CODE_ONES, 1'b1, '1, '1});
      finish_frame();
      offer(random_request(KIND_TICK));

      // Group dim frame; hold off the receiver so the block backs up, then pause
      // the sender mid-frame until every result is back.
      configure(16'd1, 16'd3, 1'b1);
      offer('{KIND_COMMAND, 1'b0, '0, 1'b1, '0, '1});
      hold_offs_asked++;
      repeat (30) offer(random_request(KIND_TICK));
      drain_results();
      finish_frame();
      offer('{KIND_COMMAND, 1'b0, CODE_W'(26'h2AAAAAA), 1'b0, UNIT_W'(5), LEVEL_W'(1)});
      finish_frame();

      // Both register fields at their top values, written while idle.
      configure(16'h03FF, 16'hFFFF, 1'b0);
      offer(random_request(KIND_TICK));

      // Random segments, two per idling mix: none, sender, receiver, both.
      for (seg = 0; seg < SEGMENTS; seg++) begin
         case (seg / 2)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 77; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 77; end
            default: begin send_gap_pct = 7; stall_pct = 7; end
         endcase
         // Change the registers only between frames.
         if (ticks_to_idle == 0)
            configure({6'($urandom()), PULSE_W'($urandom_range(2))},
                      $urandom_range(3) != 0 ? CSR_DATA_W'($urandom_range(8))
                                             : CSR_DATA_W'($urandom_range(300)),
                      1'($urandom_range(1)));
         for (n = 0; n < SEGMENT_ITEMS; n++) begin
            // Mostly start a frame when idle; now and then collide with a busy one.
            send_command = (ticks_to_idle == 0) ? ($urandom_range(99) < 85)
                                                : ($urandom_range(99) < 3);
            offer(random_request(send_command ? KIND_COMMAND : KIND_TICK));
         end
      end
      finish_frame();
      drain_results();
      repeat (10) @(negedge clock);

      $display("Run sent %0d request transactions: %0d frames started, %0d commands refused.",
               items_sent, frames_sent, commands_refused);
      $display("Frames ran with pulses of one and two ticks and stop gaps up to 300 ticks.");
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
